@@ rtl/skit_pkg.sv @@
`timescale 1ns / 1ps

package skit_pkg;

   localparam int KEY_W   = 32;
   localparam int OFF_W   = 31;
   localparam int COUNT_W = 9;
   localparam int ENTRY_W = KEY_W + OFF_W;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // Index sources for the table read port and for the captured hit position.
   typedef enum logic [2:0] {
      SEL_POS_M1,
      SEL_POS_P1,
      SEL_MID,
      SEL_LO,
      SEL_HI
   } sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SR_MID,
      ST_SR_LO,
      ST_SR_HI,
      ST_SR_CHK,
      ST_RM_RD,
      ST_RM_WR,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic    latch_req;
      logic    init_ins;
      logic    init_search;
      logic    rd_en;
      sel_type rd_sel;
      logic    wr_new;
      logic    wr_shift_up;
      logic    wr_shift_down;
      logic    save_mid;
      logic    found_en;
      sel_type found_sel;
      logic    narrow;
      logic    cnt_inc;
      logic    cnt_dec;
      logic    cnt_clr;
      logic    set_full;
      logic    set_nf;
      logic    load_rsp;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    pos_zero;
      logic    ins_greater;
      logic    rd_match;
      logic    range_ok;
      logic    shift_done;
      logic    rsp_busy;
   } sts_type;

endpackage

@@ rtl/skit_ctrl.sv @@
`timescale 1ns / 1ps

module skit_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  skit_pkg::sts_type sts,
   output skit_pkg::ctl_type ctl
);

   skit_pkg::state_type state_ff;
   skit_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skit_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      ctl.rd_sel    = skit_pkg::SEL_MID;
      ctl.found_sel = skit_pkg::SEL_MID;
      req_tready = 1'b0;
      unique case (state_ff)
         skit_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.latch_req = 1'b1;
               state_in      = skit_pkg::ST_DISPATCH;
            end
         end
         skit_pkg::ST_DISPATCH: begin
            unique case (sts.cmd) inside
               skit_pkg::CMD_INSERT: begin
                  if (sts.full) begin
                     ctl.set_full = 1'b1;
                     state_in     = skit_pkg::ST_FIN;
                  end else begin
                     ctl.init_ins = 1'b1;
                     state_in     = skit_pkg::ST_INS_RD;
                  end
               end
               skit_pkg::CMD_LOOKUP, skit_pkg::CMD_REMOVE: begin
                  ctl.init_search = 1'b1;
                  state_in        = skit_pkg::ST_SR_MID;
               end
               default: begin
                  ctl.cnt_clr = 1'b1;
                  state_in    = skit_pkg::ST_FIN;
               end
            endcase
         end
         skit_pkg::ST_INS_RD: begin
            if (sts.pos_zero) begin
               ctl.wr_new  = 1'b1;
               ctl.cnt_inc = 1'b1;
               state_in    = skit_pkg::ST_FIN;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = skit_pkg::SEL_POS_M1;
               state_in   = skit_pkg::ST_INS_CMP;
            end
         end
         skit_pkg::ST_INS_CMP: begin
            if (sts.ins_greater) begin
               ctl.wr_shift_up = 1'b1;
               state_in        = skit_pkg::ST_INS_RD;
            end else begin
               ctl.wr_new  = 1'b1;
               ctl.cnt_inc = 1'b1;
               state_in    = skit_pkg::ST_FIN;
            end
         end
         skit_pkg::ST_SR_MID: begin
            if (!sts.range_ok) begin
               ctl.set_nf = 1'b1;
               state_in   = skit_pkg::ST_FIN;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = skit_pkg::SEL_MID;
               state_in   = skit_pkg::ST_SR_LO;
            end
         end
         skit_pkg::ST_SR_LO: begin
            // read data holds the middle entry
            ctl.rd_en    = 1'b1;
            ctl.rd_sel   = skit_pkg::SEL_LO;
            ctl.save_mid = 1'b1;
            if (sts.rd_match) begin
               ctl.found_en  = 1'b1;
               ctl.found_sel = skit_pkg::SEL_MID;
               state_in = (sts.cmd == skit_pkg::CMD_LOOKUP) ? skit_pkg::ST_FIN
                                                            : skit_pkg::ST_RM_RD;
            end else begin
               state_in = skit_pkg::ST_SR_HI;
            end
         end
         skit_pkg::ST_SR_HI: begin
            // read data holds the lower-bound entry
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = skit_pkg::SEL_HI;
            if (sts.rd_match) begin
               ctl.found_en  = 1'b1;
               ctl.found_sel = skit_pkg::SEL_LO;
               state_in = (sts.cmd == skit_pkg::CMD_LOOKUP) ? skit_pkg::ST_FIN
                                                            : skit_pkg::ST_RM_RD;
            end else begin
               state_in = skit_pkg::ST_SR_CHK;
            end
         end
         skit_pkg::ST_SR_CHK: begin
            // read data holds the upper-bound entry
            if (sts.rd_match) begin
               ctl.found_en  = 1'b1;
               ctl.found_sel = skit_pkg::SEL_HI;
               state_in = (sts.cmd == skit_pkg::CMD_LOOKUP) ? skit_pkg::ST_FIN
                                                            : skit_pkg::ST_RM_RD;
            end else begin
               ctl.narrow = 1'b1;
               state_in   = skit_pkg::ST_SR_MID;
            end
         end
         skit_pkg::ST_RM_RD: begin
            if (sts.shift_done) begin
               ctl.cnt_dec = 1'b1;
               state_in    = skit_pkg::ST_FIN;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = skit_pkg::SEL_POS_P1;
               state_in   = skit_pkg::ST_RM_WR;
            end
         end
         skit_pkg::ST_RM_WR: begin
            ctl.wr_shift_down = 1'b1;
            state_in          = skit_pkg::ST_RM_RD;
         end
         skit_pkg::ST_FIN: begin
            if (!sts.rsp_busy) begin
               ctl.load_rsp = 1'b1;
               state_in     = skit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skit_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/skit_datapath.sv @@
`timescale 1ns / 1ps

module skit_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_cmd,
   input  logic [skit_pkg::KEY_W-1:0]    req_key,
   input  logic [skit_pkg::OFF_W-1:0]    req_off,
   input  skit_pkg::ctl_type             ctl,
   output skit_pkg::sts_type             sts,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [1:0]                    rsp_status,
   output logic [skit_pkg::OFF_W-1:0]    rsp_found,
   output logic [skit_pkg::COUNT_W-1:0]  rsp_count
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = skit_pkg::KEY_W;
   localparam int OW = skit_pkg::OFF_W;
   localparam int EW = skit_pkg::ENTRY_W;
   localparam int NW = skit_pkg::COUNT_W;

   logic [EW-1:0] store_ff [TABLE_DEPTH];
   logic [EW-1:0] rdata_ff;

   skit_pkg::cmd_type    cmd_ff;
   logic [KW-1:0]        key_ff;
   logic [OW-1:0]        off_ff;
   logic [KW-1:0]        mid_key_ff;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi1_ff, hi1_in;
   logic [CW-1:0]        count_ff, count_in;
   skit_pkg::status_type res_status_ff, res_status_in;
   logic [OW-1:0]        res_found_ff, res_found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   skit_pkg::status_type rsp_status_ff;
   logic [OW-1:0]        rsp_found_ff;
   logic [NW-1:0]        rsp_count_ff;

   logic [CW:0]          mid_sum;
   logic [CW-1:0]        mid;
   logic [CW-1:0]        hi;
   logic [CW-1:0]        rd_idx;
   logic [CW-1:0]        hit_idx;
   logic [CW:0]          pos_next;
   logic [CW+NW-1:0]     count_ext;
   logic                 wr_en;
   logic [EW-1:0]        wdata;
   logic [KW-1:0]        rd_key;
   logic [OW-1:0]        rd_off;

   assign rd_key  = rdata_ff[EW-1:OW];
   assign rd_off  = rdata_ff[OW-1:0];
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi1_ff} - (CW + 1)'(1);
   assign mid     = mid_sum[CW:1];
   assign hi      = hi1_ff - CW'(1);
   assign pos_next = {1'b0, pos_ff} + (CW + 1)'(1);

   always_comb begin
      unique case (ctl.rd_sel)
         skit_pkg::SEL_POS_M1: rd_idx = pos_ff - CW'(1);
         skit_pkg::SEL_POS_P1: rd_idx = pos_next[CW-1:0];
         skit_pkg::SEL_LO:     rd_idx = lo_ff;
         skit_pkg::SEL_HI:     rd_idx = hi;
         default:              rd_idx = mid;
      endcase
   end

   always_comb begin
      unique case (ctl.found_sel)
         skit_pkg::SEL_LO: hit_idx = lo_ff;
         skit_pkg::SEL_HI: hit_idx = hi;
         default:          hit_idx = mid;
      endcase
   end

   assign wr_en = ctl.wr_new | ctl.wr_shift_up | ctl.wr_shift_down;
   assign wdata = ctl.wr_new ? {key_ff, off_ff} : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[pos_ff[AW-1:0]] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= store_ff[rd_idx[AW-1:0]];
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hi1_in        = hi1_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      if (ctl.latch_req) begin
         res_status_in = skit_pkg::STATUS_OK;
         res_found_in  = '0;
      end
      if (ctl.init_ins) begin
         pos_in = count_ff;
      end
      if (ctl.init_search) begin
         lo_in  = '0;
         hi1_in = count_ff;
      end
      if (ctl.wr_shift_up) begin
         pos_in = pos_ff - CW'(1);
      end
      if (ctl.wr_shift_down) begin
         pos_in = pos_next[CW-1:0];
      end
      if (ctl.found_en) begin
         pos_in = hit_idx;
         if (cmd_ff == skit_pkg::CMD_LOOKUP) begin
            res_found_in = rd_off;
         end
      end
      if (ctl.narrow) begin
         if (mid_key_ff > key_ff) begin
            hi1_in = mid;
         end else begin
            lo_in = mid + CW'(1);
         end
      end
      if (ctl.cnt_clr) begin
         count_in = '0;
      end else if (ctl.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (ctl.set_full) begin
         res_status_in = skit_pkg::STATUS_FULL;
      end
      if (ctl.set_nf) begin
         res_status_in = skit_pkg::STATUS_NOT_FOUND;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign count_ext = {{NW{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi1_ff        <= hi1_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      if (ctl.latch_req) begin
         cmd_ff <= skit_pkg::cmd_type'(req_cmd);
         key_ff <= req_key;
         off_ff <= req_off;
      end
      if (ctl.save_mid) begin
         mid_key_ff <= rd_key;
      end
      if (ctl.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= count_ext[NW-1:0];
      end
   end

   assign sts.cmd         = cmd_ff;
   assign sts.full        = (count_ff >= CW'(TABLE_DEPTH));
   assign sts.pos_zero    = (pos_ff == '0);
   assign sts.ins_greater = (rd_key > key_ff) || ((rd_key == key_ff) && (rd_off > off_ff));
   assign sts.rd_match    = (rd_key == key_ff);
   assign sts.range_ok    = (lo_ff < hi1_ff);
   assign sts.shift_done  = (pos_next >= {1'b0, count_ff});
   assign sts.rsp_busy    = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> !(rsp_valid_ff && !rsp_tready))
      else $error("response loaded over a pending transfer");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_new |-> (count_ff < CW'(TABLE_DEPTH)) && (pos_ff <= count_ff))
      else $error("insert write with no free slot");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ctl.cnt_dec |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove did not drop the entry count by one");
`endif

endmodule

@@ rtl/sorted_key_index_table.sv @@
`timescale 1ns / 1ps
// Per command: clear empties the count; insert shifts each larger entry up one slot;
// lookup runs binary-search rounds, at most log2(TABLE_DEPTH)+1 of them, probing the
// middle, low and high entries; remove also shifts the entries above the hit down a slot.
// One command at a time through the shared single-port table; the next transfer is taken
// in the cycle after the response loads.
// Synchronous reset empties the table count and drops the response; storage is not cleared.

module sorted_key_index_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key_value, [62:32] record_offset, [63] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [30:0] found_offset, [39:31] entry_count
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   skit_pkg::ctl_type ctl;
   skit_pkg::sts_type sts;

   logic [skit_pkg::OFF_W-1:0]   rsp_found;
   logic [skit_pkg::COUNT_W-1:0] rsp_count;

   // Sequencer: owns the command flow, issues at most one table access per cycle.
   skit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // Table, search bounds, insert/remove pointer and the response register.
   // The response register lets a new request transfer while a result waits.
   skit_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_tuser),
      .req_key    (req_tdata[31:0]),
      .req_off    (req_tdata[62:32]),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_found  (rsp_found),
      .rsp_count  (rsp_count)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {rsp_count, rsp_found};

endmodule

@@ dv/sorted_key_index_table_test.sv @@
`timescale 1ns / 1ps

module sorted_key_index_table_test;

   localparam int DEPTH        = 256;
   localparam int RANDOM_ITEMS = 1600;
   // Worst insert or remove shifts the whole table.
   localparam int TAIL_CYCLES  = 2 * DEPTH + 16;
   // Bound on the whole run, well above the slowest correct run.
   localparam int LIMIT_CYCLES = 5_000_000;

   typedef struct {
      skit_pkg::cmd_type                cmd;
      logic [skit_pkg::KEY_W-1:0]       key;
      logic [skit_pkg::OFF_W-1:0]       off;
      bit                               drain;   // hold this transfer until every answer is back
   } table_cmd_type;

   typedef struct packed {
      skit_pkg::status_type             status;
      logic [skit_pkg::OFF_W-1:0]       found;
      logic [skit_pkg::COUNT_W-1:0]     count;
   } table_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;     // [31:0] key_value, [62:32] record_offset, [63] zero
   logic [1:0]  req_tuser = skit_pkg::CMD_INSERT;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [30:0] found_offset, [39:31] entry_count
   logic [1:0]  rsp_tuser;          // [1:0] status

   sorted_key_index_table #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Commands still to be driven, and answers owed by the block in order.
   table_cmd_type    command_q[$];
   table_answer_type pending_answers[$];

   // Shadow copy of the table: sorted by key, then by offset.
   logic [skit_pkg::KEY_W-1:0] tbl_key [DEPTH];
   logic [skit_pkg::OFF_W-1:0] tbl_off [DEPTH];
   int                         tbl_fill = 0;

   logic [skit_pkg::KEY_W-1:0] key_pool [32];
   int                         pool_size = 1;

   int  sent_count  = 0;
   int  rsp_count   = 0;
   int  cycle_count = 0;
   int  error_count = 0;
   bit  req_took    = 1'b0;

   // Idle phases rotate every 200 transfers: none, sender, receiver, both.
   int sender_idle_pct   [4] = '{0, 48, 0, 21};
   int receiver_stall_pct[4] = '{0, 0, 48, 21};

   function automatic int idle_phase(int n);
      return (n / 200) % 4;
   endfunction

   // Binary search with the block's probe order: middle, then low end, then high end.
   function automatic int locate_key(logic [skit_pkg::KEY_W-1:0] k);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = tbl_fill - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (tbl_key[mid] == k) return mid;
         if (tbl_key[lo] == k) return lo;
         if (tbl_key[hi] == k) return hi;
         if (tbl_key[mid] > k) hi = mid - 1;
         else lo = mid + 1;
      end
      return -1;
   endfunction

   // Apply one command to the shadow table and return the answer it owes.
   function automatic table_answer_type run_table_command(skit_pkg::cmd_type cmd,
                                                         logic [skit_pkg::KEY_W-1:0] k,
                                                         logic [skit_pkg::OFF_W-1:0] off);
      table_answer_type ans;
      int               pos;
      ans.status = skit_pkg::STATUS_OK;
      ans.found  = '0;
      case (cmd)
         skit_pkg::CMD_INSERT: begin
            if (tbl_fill >= DEPTH) begin
               ans.status = skit_pkg::STATUS_FULL;
            end else begin
               // Shift larger pairs up; an equal pair stays below the new one.
               pos = tbl_fill;
               while (pos > 0 && (tbl_key[pos-1] > k ||
                                  (tbl_key[pos-1] == k && tbl_off[pos-1] > off))) begin
                  tbl_key[pos] = tbl_key[pos-1];
                  tbl_off[pos] = tbl_off[pos-1];
                  pos--;
               end
               tbl_key[pos] = k;
               tbl_off[pos] = off;
               tbl_fill++;
            end
         end
         skit_pkg::CMD_LOOKUP: begin
            pos = locate_key(k);
            if (pos < 0) ans.status = skit_pkg::STATUS_NOT_FOUND;
            else ans.found = tbl_off[pos];
         end
         skit_pkg::CMD_REMOVE: begin
            pos = locate_key(k);
            if (pos < 0) begin
               ans.status = skit_pkg::STATUS_NOT_FOUND;
            end else begin
               for (int i = pos; i + 1 < tbl_fill; i++) begin
                  tbl_key[i] = tbl_key[i+1];
                  tbl_off[i] = tbl_off[i+1];
               end
               tbl_fill--;
            end
         end
         default: tbl_fill = 0;
      endcase
      ans.count = skit_pkg::COUNT_W'(tbl_fill);
      return ans;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      error_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
   endtask

   task automatic queue_cmd(skit_pkg::cmd_type cmd, logic [skit_pkg::KEY_W-1:0] k,
                            logic [skit_pkg::OFF_W-1:0] off, bit drain);
      table_cmd_type c;
      c.cmd   = cmd;
      c.key   = k;
      c.off   = off;
      c.drain = drain;
      command_q.push_back(c);
   endtask

   // Mostly keys from the episode's pool so that lookups and removes hit.
   function automatic logic [skit_pkg::KEY_W-1:0] pick_key();
      if ($urandom_range(9) == 0) return $urandom;
      return key_pool[$urandom_range(pool_size - 1)];
   endfunction

   // Small offsets now and then, to make equal pairs.
   function automatic logic [skit_pkg::OFF_W-1:0] pick_offset();
      int r;
      r = $urandom_range(15);
      if (r == 0) return '0;
      if (r == 1) return {skit_pkg::OFF_W{1'b1}};
      if (r < 6) return skit_pkg::OFF_W'($urandom_range(3));
      return skit_pkg::OFF_W'($urandom);
   endfunction

   // Monitor: check each response transfer, then predict each accepted command.
   always @(posedge clock) begin : watch_bus
      table_answer_type want;
      cycle_count++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (pending_answers.size() == 0) begin
               error_count++;
               $error("response transfer with no command outstanding");
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_tuser));
               if (rsp_tdata[30:0] !== want.found)
                  report_mismatch("found_offset", 32'(want.found), 32'(rsp_tdata[30:0]));
               if (rsp_tdata[39:31] !== want.count)
                  report_mismatch("entry_count", 32'(want.count), 32'(rsp_tdata[39:31]));
            end
         end
         if (req_tvalid && req_tready) begin
            pending_answers.push_back(run_table_command(skit_pkg::cmd_type'(req_tuser),
                                                        req_tdata[31:0], req_tdata[62:32]));
            sent_count++;
            req_took = 1'b1;
         end
      end
   end

   // Driver: advance after a transfer, hold an offered command until taken,
   // idle and stall at random per phase.
   always @(negedge clock) begin : drive_req
      logic hold_item;
      logic next_valid;
      hold_item  = req_tvalid && !req_took;
      next_valid = hold_item;
      if (req_took) begin
         command_q.delete(0);
         req_took = 1'b0;
      end
      if (!hold_item && !reset && command_q.size() != 0) begin
         if (!(command_q[0].drain && pending_answers.size() != 0) &&
             $urandom_range(99) >= sender_idle_pct[idle_phase(sent_count)]) begin
            next_valid = 1'b1;
            req_tdata <= {1'b0, command_q[0].off, command_q[0].key};
            req_tuser <= command_q[0].cmd;
         end
      end
      req_tvalid <= next_valid;
      rsp_tready <= !reset && ($urandom_range(99) >= receiver_stall_pct[idle_phase(rsp_count)]);
   end

   initial begin
      int  n;
      int  r;
      int  target;
      bit  fill_done;
      bit  timed_out;
      logic [skit_pkg::KEY_W-1:0] k;

      // Directed: empty table, extreme fields, equal pairs, duplicate keys,
      // absent keys, clear with stale storage behind it.
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'h0000_0000, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'h0000_0000, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'h8000_0000, 31'h4000_0000, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'h8000_0000, 31'h4000_0000, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'h8000_0000, 31'h1, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'h0000_0000, 31'h7FFF_FFFF, 1'b0);
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'h8000_0000, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_REMOVE, 32'h8000_0000, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'h8000_0000, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_REMOVE, 32'h1234_5678, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'h5555_5555, 31'h2AAA_AAAA, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'hAAAA_AAAA, 31'h5555_5555, 1'b0);
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'hAAAA_AAAA, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      queue_cmd(skit_pkg::CMD_LOOKUP, 32'h0000_0000, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_INSERT, 32'hFFFF_FFFF, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 31'h0, 1'b0);
      queue_cmd(skit_pkg::CMD_CLEAR,  32'h0, 31'h0, 1'b0);

      // Random: episodes over a small key pool, one of them filling the table.
      target    = command_q.size() + RANDOM_ITEMS;
      fill_done = 1'b0;
      while (command_q.size() < target) begin
         pool_size = $urandom_range(24, 2);
         for (int i = 0; i < pool_size; i++) begin
            r = $urandom_range(15);
            key_pool[i] = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
         end
         if (!fill_done && command_q.size() > target / 2) begin
            // Drain first, then fill past capacity, probe, free a few, refill.
            fill_done = 1'b1;
            queue_cmd(skit_pkg::CMD_CLEAR, $urandom, pick_offset(), 1'b1);
            for (int j = 0; j < DEPTH + 2; j++) begin
               k = ($urandom_range(3) == 0) ? pick_key() : 32'($urandom);
               queue_cmd(skit_pkg::CMD_INSERT, k, pick_offset(), 1'b0);
            end
            for (int j = 0; j < 20; j++)
               queue_cmd(skit_pkg::CMD_LOOKUP, pick_key(), pick_offset(), 1'b0);
            for (int j = 0; j < 10; j++)
               queue_cmd(skit_pkg::CMD_REMOVE, pick_key(), pick_offset(), 1'b0);
            for (int j = 0; j < 12; j++)
               queue_cmd(skit_pkg::CMD_INSERT, pick_key(), pick_offset(), 1'b0);
            queue_cmd(skit_pkg::CMD_CLEAR, $urandom, pick_offset(), 1'b0);
         end else begin
            if ($urandom_range(1) == 0)
               queue_cmd(skit_pkg::CMD_CLEAR, $urandom, pick_offset(), 1'b0);
            n = $urandom_range(80, 20);
            for (int j = 0; j < n; j++) begin
               r = $urandom_range(99);
               if (r < 45)
                  queue_cmd(skit_pkg::CMD_INSERT, pick_key(), pick_offset(), 1'b0);
               else if (r < 75)
                  queue_cmd(skit_pkg::CMD_LOOKUP, pick_key(), pick_offset(), 1'b0);
               else if (r < 97)
                  queue_cmd(skit_pkg::CMD_REMOVE, pick_key(), pick_offset(), 1'b0);
               else
                  queue_cmd(skit_pkg::CMD_CLEAR, pick_key(), pick_offset(), 1'b0);
            end
         end
      end

      // Hold reset at the start; release it after a rising edge so the driver sees it low.
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while ((command_q.size() != 0 || pending_answers.size() != 0) &&
             cycle_count < LIMIT_CYCLES)
         @(negedge clock);
      timed_out = (cycle_count >= LIMIT_CYCLES);
      // Watch a while longer for stray responses.
      if (!timed_out) repeat (TAIL_CYCLES) @(negedge clock);
      if (!timed_out && error_count == 0 && pending_answers.size() == 0)
         $display("sorted_key_index_table verification clean");
      else
         $display("sorted_key_index_table verification failed");
      $finish;
   end

endmodule
